// File: src/fmrs_pkg.sv
// Fan motor reversing supervisor: shared types, register indexes and reset constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fmrs_pkg;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_REV  = 2'd2;
  localparam logic [1:0] CMD_STOP = 2'd3;

  localparam logic [1:0] REG_SWITCH_DELAY     = 2'd0;
  localparam logic [1:0] REG_DIRECTION_PERIOD = 2'd1;
  localparam logic [1:0] REG_FAULT_DELAY      = 2'd2;

  localparam logic [7:0]  SWITCH_DELAY_RST     = 8'd3;
  localparam logic [15:0] DIRECTION_PERIOD_RST = 16'd300;
  localparam logic [7:0]  FAULT_DELAY_RST      = 8'd15;

  localparam logic [2:0] MODE_CODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_CODE_FWD  = 3'd1;
  localparam logic [2:0] MODE_CODE_REV  = 3'd2;
  localparam logic [2:0] MODE_CODE_WAIT = 3'd3;
  localparam logic [2:0] MODE_CODE_STOP = 3'd4;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_NOT_OFF = 2'd1;
  localparam logic [1:0] FAULT_NOT_RUN = 2'd2;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_FWD  = 5'b00010,
    MODE_REV  = 5'b00100,
    MODE_WAIT = 5'b01000,
    MODE_STOP = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0]  switch_delay;
    logic [15:0] direction_period;
    logic [7:0]  fault_delay;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        last_was_forward;
    logic [7:0]  switch_count;
    logic [15:0] period_count;
    logic [7:0]  fault_count;
    logic        forward_relay;
    logic        reverse_relay;
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       motor_running;
    logic       sequence_paused;
    logic       machine_paused;
  } item_t;

  typedef struct packed {
    logic       forward_drive;
    logic       reverse_drive;
    logic       running_seen;
    logic [2:0] mode;
    logic [1:0] fault;
    logic       restart_pulse;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_FWD:  c = MODE_CODE_FWD;
      MODE_REV:  c = MODE_CODE_REV;
      MODE_WAIT: c = MODE_CODE_WAIT;
      MODE_STOP: c = MODE_CODE_STOP;
      default:   c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/fmrs_in_if.sv
// Input channel of the fan motor reversing supervisor: one supervision tick per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface fmrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       motor_running;
  logic       sequence_paused;
  logic       machine_paused;

  modport source (output valid, cmd, motor_running, sequence_paused, machine_paused,
                  input ready);
  modport sink   (input valid, cmd, motor_running, sequence_paused, machine_paused,
                  output ready);
endinterface
`default_nettype wire

// File: src/fmrs_out_if.sv
// Result channel of the fan motor reversing supervisor: one result per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface fmrs_out_if;
  logic       valid;
  logic       ready;
  logic       forward_drive;
  logic       reverse_drive;
  logic       running_seen;
  logic [2:0] mode;
  logic [1:0] fault;
  logic       restart_pulse;

  modport source (output valid, forward_drive, reverse_drive, running_seen, mode, fault,
                  restart_pulse, input ready);
  modport sink   (input valid, forward_drive, reverse_drive, running_seen, mode, fault,
                  restart_pulse, output ready);
endinterface
`default_nettype wire

// File: src/fmrs_cfg_if.sv
// Configuration write channel of the fan motor reversing supervisor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface fmrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/fmrs_step.sv
// Next-state and result logic for one supervision tick.
// Depends on fmrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fmrs_step
  import fmrs_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  logic [7:0] switch_reload;
  logic [1:0] fault;
  logic       fwd_start;

  assign switch_reload = (cfg.switch_delay == 8'd0) ? 8'd1 : cfg.switch_delay;

  always_comb begin
    nxt       = cur;
    fault     = FAULT_NONE;
    fwd_start = 1'b0;

    unique case (item.cmd)
      CMD_FWD:  nxt.mode = MODE_FWD;
      CMD_REV:  nxt.mode = MODE_REV;
      CMD_STOP: nxt.mode = MODE_STOP;
      default:  nxt.mode = cur.mode;
    endcase

    if (!item.sequence_paused) begin
      fwd_start = (nxt.mode == MODE_FWD);
      unique case (nxt.mode)
        MODE_FWD, MODE_REV: begin
          if (cur.switch_count != 8'd0) begin
            nxt.forward_relay = 1'b0;
            nxt.reverse_relay = 1'b0;
            nxt.switch_count  = cur.switch_count - 8'd1;
          end else begin
            nxt.forward_relay    = fwd_start;
            nxt.reverse_relay    = !fwd_start;
            nxt.last_was_forward = fwd_start;
            nxt.switch_count     = switch_reload;
            nxt.period_count     = cfg.direction_period;
            nxt.mode             = MODE_WAIT;
          end
        end
        MODE_WAIT: begin
          if (cur.period_count != 16'd0) begin
            nxt.period_count = cur.period_count - 16'd1;
          end else begin
            nxt.mode         = cur.last_was_forward ? MODE_REV : MODE_FWD;
            nxt.period_count = cfg.direction_period;
          end
        end
        MODE_STOP: begin
          nxt.forward_relay = 1'b0;
          nxt.reverse_relay = 1'b0;
          if (item.motor_running && cur.fault_count != 8'd0) begin
            nxt.fault_count = cur.fault_count - 8'd1;
          end else begin
            if (item.motor_running) begin
              fault = FAULT_NOT_OFF;
            end
            nxt.mode        = MODE_IDLE;
            nxt.fault_count = cfg.fault_delay;
          end
        end
        default: begin
        end
      endcase

      // running check sees the mode and fault count left by the sequence step
      if ((nxt.mode == MODE_FWD || nxt.mode == MODE_REV || nxt.mode == MODE_WAIT) &&
          !item.machine_paused) begin
        if (item.motor_running) begin
          nxt.fault_count = cfg.fault_delay;
        end else if (nxt.fault_count != 8'd0) begin
          nxt.fault_count = nxt.fault_count - 8'd1;
        end else begin
          fault           = FAULT_NOT_RUN;
          nxt.fault_count = cfg.fault_delay;
        end
      end
    end

    res.forward_drive = nxt.forward_relay;
    res.reverse_drive = nxt.reverse_relay;
    res.running_seen  = item.motor_running;
    res.mode          = mode_code(nxt.mode);
    res.fault         = fault;
    res.restart_pulse = (fault == FAULT_NOT_RUN);
  end

endmodule
`default_nettype wire

// File: src/fan_motor_reversing_supervisor_unit.sv
// Top level of the fan motor reversing supervisor: channels, configuration and state.
// Depends on fmrs_pkg, fmrs_in_if, fmrs_out_if, fmrs_cfg_if and fmrs_step.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction is one supervision tick and yields exactly one result. A tick is
// taken into an input register, evaluated by the step logic (compare and
// decrement on the three counters) which updates the supervisor state, and the result is
// held in an output register. The result becomes valid when the registered tick advances
// into the output register, which waits while an earlier result is still untaken; one tick
// is accepted every cycle while the result side keeps taking results. Configuration writes
// are always accepted; a new value takes effect the next time a counter reloads.
module fan_motor_reversing_supervisor_unit
  import fmrs_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  fmrs_in_if.sink     in_ch,
  fmrs_out_if.source  out_ch,
  fmrs_cfg_if.sink    cfg_ch
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  logic    item_v_r;
  result_t res_nxt;
  result_t res_r;
  logic    res_v_r;
  logic    advance;

  assign advance      = item_v_r && (!res_v_r || out_ch.ready);
  assign in_ch.ready  = !item_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.switch_delay     <= SWITCH_DELAY_RST;
      cfg_r.direction_period <= DIRECTION_PERIOD_RST;
      cfg_r.fault_delay      <= FAULT_DELAY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SWITCH_DELAY:     cfg_r.switch_delay     <= cfg_ch.data[7:0];
        REG_DIRECTION_PERIOD: cfg_r.direction_period <= cfg_ch.data;
        REG_FAULT_DELAY:      cfg_r.fault_delay      <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.cmd             <= in_ch.cmd;
      item_r.motor_running   <= in_ch.motor_running;
      item_r.sequence_paused <= in_ch.sequence_paused;
      item_r.machine_paused  <= in_ch.machine_paused;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      state_r.mode             <= MODE_IDLE;
      state_r.last_was_forward <= 1'b0;
      state_r.switch_count     <= SWITCH_DELAY_RST;
      state_r.period_count     <= DIRECTION_PERIOD_RST;
      state_r.fault_count      <= FAULT_DELAY_RST;
      state_r.forward_relay    <= 1'b0;
      state_r.reverse_relay    <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        item_v_r <= in_ch.valid;
      end
      if (advance) begin
        res_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_ch.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  fmrs_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign out_ch.valid         = res_v_r;
  assign out_ch.forward_drive = res_r.forward_drive;
  assign out_ch.reverse_drive = res_r.reverse_drive;
  assign out_ch.running_seen  = res_r.running_seen;
  assign out_ch.mode          = res_r.mode;
  assign out_ch.fault         = res_r.fault;
  assign out_ch.restart_pulse = res_r.restart_pulse;

`ifndef ASSERT_OFF
  a_relays_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.forward_relay && state_r.reverse_relay))
    else $error("both direction relays closed");

  a_restart_with_fault: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> (res_r.restart_pulse == (res_r.fault == FAULT_NOT_RUN)))
    else $error("restart pulse without not-running fault");

  a_not_off_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && res_r.fault == FAULT_NOT_OFF) |->
      (res_r.mode == MODE_CODE_IDLE && !res_r.forward_drive && !res_r.reverse_drive))
    else $error("not-turning-off fault without idle and open relays");

  a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a tick");
`endif

endmodule
`default_nettype wire
